@@ hw/rtl/cms_pkg.sv @@
`timescale 1ns / 1ps

package cms_pkg;

    localparam int WinDepth = 9;
    localparam int CloseLen = 3;
    localparam int CntWidth = 4;

    typedef logic [7:0]          byte_t;
    typedef logic [CntWidth-1:0] cnt_t;
    typedef byte_t               win_t [WinDepth];

    localparam cnt_t WinFull  = cnt_t'(WinDepth);
    localparam cnt_t CloseCnt = cnt_t'(CloseLen);
    localparam cnt_t CntOne   = cnt_t'(1);
    // A closer right behind the head byte leaves this many bytes before the emit.
    localparam cnt_t CloseAfterEmit = cnt_t'(CloseLen + 1);

    localparam byte_t OpenerPat [WinDepth] = '{
        8'h3C, 8'h21, 8'h5B, 8'h63, 8'h64, 8'h61, 8'h74, 8'h61, 8'h5B
    };
    localparam byte_t CloserPat [CloseLen] = '{8'h5D, 8'h5D, 8'h3E};

    localparam byte_t UpperA   = 8'h41;
    localparam byte_t UpperZ   = 8'h5A;
    localparam byte_t CaseStep = 8'h20;

    // One result item as it sits in the output queue.
    typedef struct packed {
        byte_t out_byte;
        logic  out_valid;
        logic  out_end;
    } res_t;

    // Outcome of one decision on the window head.
    typedef struct packed {
        logic  opener;
        logic  closer;
        byte_t head;
        logic  emit_last;
    } dec_t;

    function automatic byte_t fold_case(input byte_t c);
        byte_t r;
        r = c;
        if (c >= UpperA && c <= UpperZ)
        begin
            r = c + CaseStep;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cms_in_if.sv @@
`timescale 1ns / 1ps

interface cms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/cms_out_if.sv @@
`timescale 1ns / 1ps

interface cms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;

    modport source (output valid, output out_byte, output out_valid, output out_end,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_end,
                    output ready);
endinterface

@@ hw/rtl/cms_decide.sv @@
`timescale 1ns / 1ps

module cms_decide (
    input  cms_pkg::byte_t win [cms_pkg::WinDepth],
    input  cms_pkg::cnt_t  cnt,
    input  logic           sect_open,
    output cms_pkg::dec_t  dec
);
    import cms_pkg::*;

    logic open_match;
    logic close_match;
    logic close_next;

    always_comb
    begin
        open_match  = 1'b1;
        close_match = 1'b1;
        close_next  = 1'b1;
        for (int k = 0; k < WinDepth; k++)
        begin
            if (fold_case(win[k]) != OpenerPat[k])
            begin
                open_match = 1'b0;
            end
        end
        for (int k = 0; k < CloseLen; k++)
        begin
            if (win[k] != CloserPat[k])
            begin
                close_match = 1'b0;
            end
            if (win[k+1] != CloserPat[k])
            begin
                close_next = 1'b0;
            end
        end

        dec.opener = open_match && (cnt == WinFull);
        dec.closer = !dec.opener && sect_open && close_match && (cnt >= CloseCnt);
        dec.head   = win[0];
        // During a drain an emitted byte is the final one when nothing remains
        // after it, or when only a closer remains inside a section.
        dec.emit_last = (cnt == CntOne) ||
                        (sect_open && close_next && (cnt == CloseAfterEmit));
    end

endmodule

@@ hw/rtl/cms_out_fifo.sv @@
`timescale 1ns / 1ps

module cms_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cms_pkg::res_t    push_data,
    output logic             can_push,
    cms_out_if.source        out_ch
);
    import cms_pkg::*;

    res_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop      = out_ch.valid && out_ch.ready;
    assign can_push = (cnt_reg != 2'd2);

    assign out_ch.valid     = (cnt_reg != 2'd0);
    assign out_ch.out_byte  = mem_reg[rd_ptr_reg].out_byte;
    assign out_ch.out_valid = mem_reg[rd_ptr_reg].out_valid;
    assign out_ch.out_end   = mem_reg[rd_ptr_reg].out_end;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/cdata_marker_stripper_unit.sv @@
`timescale 1ns / 1ps

// CDATA marker stripper. Bytes of a document arrive one per transfer on in_ch and
// enter a nine-byte lookahead window; filtered bytes leave on out_ch. Once the window
// is full, each input byte causes one decision on the window head: an opener
// "<![CDATA[" (letters in any case) drops all nine bytes and marks the stream as
// inside a section, a "]]>" inside a section drops three bytes and leaves it, and any
// other head byte is passed on. In steady state the block takes one byte per clock
// cycle while the output queue has room, limited by the single decision unit that
// examines the window once a cycle; each result is registered in the output queue
// before it reaches out_ch. A transfer with in_last set starts a drain: input stalls
// while the window is emptied, one decision per cycle while the queue has room. The
// final result of a document carries out_end; a document that yields no byte at all
// ends with a single result with out_valid low and out_byte zero. After the drain the
// window is empty and the next byte starts a new document.
// A two-entry output queue lets input keep flowing while a result waits on out_ch.

module cdata_marker_stripper_unit (
    input  logic      clk,
    input  logic      rst_n,
    cms_in_if.sink    in_ch,
    cms_out_if.source out_ch
);
    import cms_pkg::*;

    byte_t win_reg   [WinDepth];
    byte_t win_next  [WinDepth];
    byte_t win_app   [WinDepth];
    byte_t dec_win   [WinDepth];
    byte_t win_sh1   [WinDepth];
    byte_t win_sh3   [WinDepth];
    byte_t win_after [WinDepth];

    cnt_t cnt_reg;
    cnt_t cnt_next;
    cnt_t cnt_app;
    cnt_t dec_cnt;
    cnt_t cnt_after;

    logic inside_reg;
    logic inside_next;
    logic inside_after;
    logic drain_reg;
    logic drain_next;
    logic any_reg;
    logic any_next;

    logic in_fire;
    logic step;
    logic emit;
    logic push;
    logic can_push;
    res_t push_data;
    dec_t dec;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !drain_reg && can_push;

    cms_decide u_decide (
        .win       (dec_win),
        .cnt       (dec_cnt),
        .sect_open (inside_reg),
        .dec       (dec)
    );

    cms_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .out_ch    (out_ch)
    );

    // Window with the incoming byte placed behind the bytes already held.
    always_comb
    begin
        for (int i = 0; i < WinDepth; i++)
        begin
            win_app[i] = (cnt_reg == cnt_t'(i)) ? in_ch.in_byte : win_reg[i];
        end
        cnt_app = cnt_reg + CntOne;
    end

    // The decision looks at the appended window on a normal transfer and at the
    // held window during a drain.
    always_comb
    begin
        for (int i = 0; i < WinDepth; i++)
        begin
            dec_win[i] = drain_reg ? win_reg[i] : win_app[i];
        end
        dec_cnt = drain_reg ? cnt_reg : cnt_app;
        step    = drain_reg ? can_push : (in_fire && !in_ch.in_last && (cnt_app == WinFull));
        emit    = !dec.opener && !dec.closer;
    end

    // Window after one decision: cleared, shifted by three or shifted by one.
    always_comb
    begin
        for (int i = 0; i < WinDepth; i++)
        begin
            win_sh1[i] = (i + 1 < WinDepth) ? dec_win[(i + 1) % WinDepth] : dec_win[i];
            win_sh3[i] = (i + CloseLen < WinDepth) ? dec_win[(i + CloseLen) % WinDepth]
                                                   : dec_win[i];
        end
        if (dec.opener)
        begin
            win_after    = dec_win;
            cnt_after    = '0;
            inside_after = 1'b1;
        end
        else if (dec.closer)
        begin
            win_after    = win_sh3;
            cnt_after    = dec_cnt - CloseCnt;
            inside_after = 1'b0;
        end
        else
        begin
            win_after    = win_sh1;
            cnt_after    = dec_cnt - CntOne;
            inside_after = inside_reg;
        end
    end

    // Next state of the window and the drain control.
    always_comb
    begin
        win_next    = win_reg;
        cnt_next    = cnt_reg;
        inside_next = inside_reg;
        drain_next  = drain_reg;
        any_next    = any_reg;
        if (step)
        begin
            win_next    = win_after;
            cnt_next    = cnt_after;
            inside_next = inside_after;
            if (drain_reg)
            begin
                any_next = any_reg || emit;
                if (cnt_after == '0)
                begin
                    drain_next  = 1'b0;
                    inside_next = 1'b0;
                end
            end
        end
        else if (in_fire)
        begin
            win_next = win_app;
            cnt_next = cnt_app;
            if (in_ch.in_last)
            begin
                drain_next = 1'b1;
                any_next   = 1'b0;
            end
        end
    end

    // A result goes to the queue for every emitted byte, and once as an empty end
    // marker when a drain finishes without having emitted anything.
    always_comb
    begin
        push = step && (emit || (drain_reg && (cnt_after == '0) && !any_reg));
        if (emit)
        begin
            push_data.out_byte  = dec.head;
            push_data.out_valid = 1'b1;
            push_data.out_end   = drain_reg && dec.emit_last;
        end
        else
        begin
            push_data.out_byte  = '0;
            push_data.out_valid = 1'b0;
            push_data.out_end   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            inside_reg <= 1'b0;
            drain_reg  <= 1'b0;
            any_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            inside_reg <= inside_next;
            drain_reg  <= drain_next;
            any_reg    <= any_next;
        end
    end

endmodule
